// File: rtl/core/rvc_pkg.sv
// ----------------------------------------------------------------------------
// rvc_pkg
// shared constants, types and register indexes of the vignetting corrector
// ----------------------------------------------------------------------------
package rvc_pkg;

    localparam int COORD_BITS_DEF   = 13;
    localparam int RADIUS_SHIFT_DEF = 10;

    localparam int CW        = 13;   // coordinate field width
    localparam int S_FRAC    = 16;
    localparam int S_BITS    = 24;
    localparam int S2_BITS   = 32;
    localparam int S3_BITS   = 40;
    localparam int S3_HALF   = 20;
    localparam int K_BITS    = 21;
    localparam int Q_FRAC    = 33;
    localparam int Q_BITS    = 64;
    localparam int N_BITS    = 8 + Q_FRAC;
    localparam int CMP_BITS  = Q_BITS + 8;
    localparam int DIV_STEPS = 8;

    localparam int RAD_STG   = 4;
    localparam int LANE_STG  = 3 + DIV_STEPS;
    localparam int NUM_STG   = RAD_STG + LANE_STG + 1;
    localparam int NUM_LANES = 3;

    localparam logic [7:0] PIX_MAX = 8'd255;

    typedef logic [S_BITS-1:0]  s1_t;
    typedef logic [S2_BITS-1:0] s2_t;
    typedef logic [S3_BITS-1:0] s3_t;
    typedef logic signed [K_BITS-1:0] coef_t;

    typedef enum logic [2:0] {
        CFG_COLOR_MODE = 3'd0,
        CFG_CENTER_X   = 3'd1,
        CFG_CENTER_Y   = 3'd2,
        CFG_COEF_CH0   = 3'd3,
        CFG_COEF_CH1   = 3'd4,
        CFG_COEF_CH2   = 3'd5
    } cfg_idx_t;

endpackage

// File: rtl/core/rvc_radius.sv
// ----------------------------------------------------------------------------
// rvc_radius
// squared distance to the centre, scaled and saturated, with its powers
// ----------------------------------------------------------------------------
module rvc_radius
    import rvc_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int RADIUS_SHIFT = RADIUS_SHIFT_DEF
)
(
    input  logic                clk,
    input  logic [RAD_STG-1:0]  en,
    input  logic [CW-1:0]       pix_col,
    input  logic [CW-1:0]       pix_row,
    input  logic [CW-1:0]       center_x,
    input  logic [CW-1:0]       center_y,
    output s1_t                 s1,
    output s2_t                 s2,
    output s3_t                 s3
);

    localparam logic [CW-1:0] CMASK =
        (COORD_BITS >= CW) ? {CW{1'b1}} : CW'((1 << COORD_BITS) - 1);
    localparam int D2W = 2 * CW + 1;
    localparam int SXW = D2W + S_FRAC;

    logic signed [CW:0]     dx, dy;
    logic [2*CW-1:0]        sqx_reg, sqy_reg;
    logic [D2W-1:0]         d2;
    logic [SXW-1:0]         sx;
    s1_t                    s1_next, s1_reg, s1b_reg, s1c_reg;
    logic [2*S_BITS-1:0]    p2;
    s2_t                    s2_reg;
    logic [S2_BITS+S_BITS-1:0] p3;
    s2_t                    s2b_reg;
    s3_t                    s3_reg;

    assign dx = $signed({1'b0, pix_col & CMASK}) - $signed({1'b0, center_x & CMASK});
    assign dy = $signed({1'b0, pix_row & CMASK}) - $signed({1'b0, center_y & CMASK});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sqx_reg <= (2*CW)'(dx * dx);
            sqy_reg <= (2*CW)'(dy * dy);
        end
    end

    assign d2 = D2W'(sqx_reg) + D2W'(sqy_reg);
    assign sx = {d2, {S_FRAC{1'b0}}} >> (2 * RADIUS_SHIFT);
    // far radius saturates just under 256.0
    assign s1_next = (sx > SXW'({S_BITS{1'b1}})) ? {S_BITS{1'b1}} : S_BITS'(sx);

    assign p2 = s1_reg * s1_reg;
    assign p3 = s2_reg * s1b_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
            s1_reg <= s1_next;
        if (en[2])
        begin
            s2_reg  <= p2[S_FRAC +: S2_BITS];
            s1b_reg <= s1_reg;
        end
        if (en[3])
        begin
            s3_reg  <= p3[S_FRAC +: S3_BITS];
            s2b_reg <= s2_reg;
            s1c_reg <= s1b_reg;
        end
    end

    assign s1 = s1c_reg;
    assign s2 = s2b_reg;
    assign s3 = s3_reg;

endmodule

// File: rtl/core/rvc_lane.sv
// ----------------------------------------------------------------------------
// rvc_lane
// one channel: gain polynomial, then a pipelined restoring divide
// ----------------------------------------------------------------------------
module rvc_lane
    import rvc_pkg::*;
(
    input  logic                clk,
    input  logic [LANE_STG-1:0] en,
    input  s1_t                 s1,
    input  s2_t                 s2,
    input  s3_t                 s3,
    input  coef_t               k1,
    input  coef_t               k2,
    input  coef_t               k3,
    input  logic [7:0]          val,
    output logic [7:0]          res
);

    logic signed [K_BITS+S_BITS:0]   t1_reg;
    logic signed [K_BITS+S2_BITS:0]  t2_reg;
    logic signed [K_BITS+S3_HALF:0]  t3lo_reg, t3hi_reg;
    logic [7:0]                      v1_reg, v2_reg;
    logic signed [Q_BITS-1:0]        q_reg;

    logic [Q_BITS-2:0]   qa_reg   [DIV_STEPS+1];
    logic [N_BITS-1:0]   rem_reg  [DIV_STEPS+1];
    logic [7:0]          quot_reg [DIV_STEPS+1];
    logic                zf_reg   [DIV_STEPS+1];
    logic                sat_reg  [DIV_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t1_reg   <= k1 * $signed({1'b0, s1});
            t2_reg   <= k2 * $signed({1'b0, s2});
            t3lo_reg <= k3 * $signed({1'b0, s3[S3_HALF-1:0]});
            t3hi_reg <= k3 * $signed({1'b0, s3[S3_BITS-1:S3_HALF]});
            v1_reg   <= val;
        end
        if (en[1])
        begin
            q_reg  <= (Q_BITS'(1) <<< Q_FRAC) + Q_BITS'(t1_reg) + Q_BITS'(t2_reg)
                    + Q_BITS'(t3lo_reg) + (Q_BITS'(t3hi_reg) <<< S3_HALF);
            v2_reg <= v1_reg;
        end
    end

    // divide set-up: quotient of 256 or more clamps, zero/negative q handled here
    logic [N_BITS-1:0] num;
    assign num = {v2_reg, {Q_FRAC{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            qa_reg[0]   <= q_reg[Q_BITS-2:0];
            rem_reg[0]  <= num;
            quot_reg[0] <= '0;
            zf_reg[0]   <= q_reg[Q_BITS-1] || (v2_reg == 8'd0);
            sat_reg[0]  <= CMP_BITS'(num) >= {1'b0, q_reg[Q_BITS-2:0], 8'd0};
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int B = DIV_STEPS - 1 - j;
        logic [CMP_BITS-1:0] trial;
        logic                take;

        assign trial = CMP_BITS'(qa_reg[j]) << B;
        assign take  = CMP_BITS'(rem_reg[j]) >= trial;

        always_ff @(posedge clk)
        begin
            if (en[3+j])
            begin
                qa_reg[j+1]   <= qa_reg[j];
                rem_reg[j+1]  <= take ? N_BITS'(CMP_BITS'(rem_reg[j]) - trial)
                                      : rem_reg[j];
                quot_reg[j+1] <= quot_reg[j] | (take ? 8'(1 << B) : 8'd0);
                zf_reg[j+1]   <= zf_reg[j];
                sat_reg[j+1]  <= sat_reg[j];
            end
        end
    end

    always_comb
    begin
        priority if (zf_reg[DIV_STEPS])
            res = 8'd0;
        else if (sat_reg[DIV_STEPS])
            res = PIX_MAX;
        else
            res = quot_reg[DIV_STEPS];
    end

endmodule

// File: rtl/core/radial_vignetting_correction.sv
// throughput: one item per cycle while the output is not stalled; the
// eight-stage divide in each lane sets the depth
// stages stall individually, so empty stages fill while the output waits
// reset (rst_n, asynchronous, active low) clears stage valids and the configuration
// registers to zero: mono mode, centre at origin, all coefficients zero
// ----------------------------------------------------------------------------
// radial_vignetting_correction
// per-pixel radial gain correction over three parallel channel lanes
// ----------------------------------------------------------------------------
module radial_vignetting_correction
    import rvc_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int RADIUS_SHIFT = RADIUS_SHIFT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // pix_col, pix_row, in_ch0, in_ch1, in_ch2, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_ch0, out_ch1, out_ch2
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic          color_mode_reg;
    logic [CW-1:0] center_x_reg, center_y_reg;
    logic [62:0]   coef_reg [NUM_LANES];

    logic [NUM_STG-1:0] vld_reg, en;
    logic [7:0]         chan_reg [RAD_STG][NUM_LANES];
    logic [7:0]         res      [NUM_LANES];
    logic [23:0]        out_reg;
    s1_t s1;
    s2_t s2;
    s3_t s3;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b0;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            for (int i = 0; i < NUM_LANES; i++)
                coef_reg[i] <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COLOR_MODE: color_mode_reg <= cfg_data[0];
                CFG_CENTER_X:   center_x_reg   <= cfg_data[CW-1:0];
                CFG_CENTER_Y:   center_y_reg   <= cfg_data[CW-1:0];
                CFG_COEF_CH0:   coef_reg[0]    <= cfg_data[62:0];
                CFG_COEF_CH1:   coef_reg[1]    <= cfg_data[62:0];
                CFG_COEF_CH2:   coef_reg[2]    <= cfg_data[62:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        en[NUM_STG-1] = !vld_reg[NUM_STG-1] || m_tready;
        for (int i = NUM_STG - 2; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
    end

    assign s_tready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            for (int i = 0; i < NUM_STG; i++)
                if (en[i])
                    vld_reg[i] <= (i == 0) ? s_tvalid : vld_reg[(i == 0) ? 0 : i-1];
        end
    end

    // channel values ride alongside the radius stages
    always_ff @(posedge clk)
    begin
        for (int st = 0; st < RAD_STG; st++)
            if (en[st])
                for (int l = 0; l < NUM_LANES; l++)
                    chan_reg[st][l] <= (st == 0) ? s_tdata[2*CW + 8*l +: 8]
                                                 : chan_reg[(st == 0) ? 0 : st-1][l];
    end

    rvc_radius #(
        .COORD_BITS   (COORD_BITS),
        .RADIUS_SHIFT (RADIUS_SHIFT)
    ) u_radius (
        .clk      (clk),
        .en       (en[RAD_STG-1:0]),
        .pix_col  (s_tdata[CW-1:0]),
        .pix_row  (s_tdata[2*CW-1:CW]),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .s1       (s1),
        .s2       (s2),
        .s3       (s3)
    );

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        rvc_lane u_lane (
            .clk (clk),
            .en  (en[RAD_STG +: LANE_STG]),
            .s1  (s1),
            .s2  (s2),
            .s3  (s3),
            .k1  (coef_reg[l][K_BITS-1:0]),
            .k2  (coef_reg[l][2*K_BITS-1:K_BITS]),
            .k3  (coef_reg[l][3*K_BITS-1:2*K_BITS]),
            .val (chan_reg[RAD_STG-1][l]),
            .res (res[l])
        );
    end

    // merge: mono mode keeps channel 0 only
    always_ff @(posedge clk)
    begin
        if (en[NUM_STG-1])
            out_reg <= {color_mode_reg ? res[2] : 8'd0,
                        color_mode_reg ? res[1] : 8'd0,
                        res[0]};
    end

    assign m_tvalid = vld_reg[NUM_STG-1];
    assign m_tdata  = out_reg;

    a_mono_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !color_mode_reg) |-> (m_tdata[23:8] == 16'd0))
        else $error("mono item with nonzero upper channels");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((&vld_reg) && !m_tready) |-> !s_tready)
        else $error("item accepted into a full stalled pipeline");

    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NUM_STG-2] && !en[NUM_STG-2]) |=> vld_reg[NUM_STG-2])
        else $error("stalled stage lost its item");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// streams pixels through the vignetting corrector under several register
// settings; each output item is checked against a listed value or a local fixed-point gain model
// ----------------------------------------------------------------------------
module testbench;
    import rvc_pkg::*;

    localparam int  LATENCY_WAIT = 24;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  RESET_ROWS   = 3;
    localparam int  NUM_PHASES   = 8;
    localparam int  PHASE_ITEMS  = 180;
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [12:0] col;
        logic [12:0] row;
        logic [7:0]  ch0;
        logic [7:0]  ch1;
        logic [7:0]  ch2;
    } pixel_t;

    typedef struct {
        pixel_t      pix;
        bit          typed;
        logic [23:0] outs;
    } pixel_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    // local copy of the registers
    logic        mode_color;
    logic [12:0] cen_x;
    logic [12:0] cen_y;
    logic [62:0] gain_coef [3];

    logic [23:0] corrected_q [$];
    int          mismatches;
    int          cycles;
    bit          calm;

    radial_vignetting_correction u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [62:0] pack_coef(int k1, int k2, int k3);
        logic [20:0] a;
        logic [20:0] b;
        logic [20:0] c;
        a = k1[20:0];
        b = k2[20:0];
        c = k3[20:0];
        return {c, b, a};
    endfunction

    function automatic logic [7:0] lane_gain(logic [7:0] v, logic [62:0] k,
                                             longint s1, longint s2, longint s3);
        coef_t             k1;
        coef_t             k2;
        coef_t             k3;
        longint            q;
        longint unsigned   num;
        longint unsigned   r;
        k1 = k[20:0];
        k2 = k[41:21];
        k3 = k[62:42];
        q = longint'(1) <<< Q_FRAC;
        q += longint'(k1) * s1;
        q += longint'(k2) * s2;
        q += longint'(k3) * s3;
        if (q < 0)
            return 8'd0;
        if (q == 0)
            return (v != 8'd0) ? PIX_MAX : 8'd0;
        num = longint'(v) << Q_FRAC;
        r = num / longint'(q);
        return (r > 255) ? PIX_MAX : r[7:0];
    endfunction

    function automatic logic [23:0] corrected_pixel(pixel_t p);
        longint dx;
        longint dy;
        longint s1;
        longint s2;
        longint s3;
        logic [7:0] o0;
        logic [7:0] o1;
        logic [7:0] o2;
        dx = longint'(p.col) - longint'(cen_x);
        dy = longint'(p.row) - longint'(cen_y);
        s1 = (dx * dx + dy * dy) >> (2 * RADIUS_SHIFT_DEF - S_FRAC);
        if (s1 > 64'hFFFFFF)
            s1 = 64'hFFFFFF;
        s2 = (s1 * s1) >> S_FRAC;
        s3 = (s2 * s1) >> S_FRAC;
        o0 = lane_gain(p.ch0, gain_coef[0], s1, s2, s3);
        o1 = mode_color ? lane_gain(p.ch1, gain_coef[1], s1, s2, s3) : 8'd0;
        o2 = mode_color ? lane_gain(p.ch2, gain_coef[2], s1, s2, s3) : 8'd0;
        return {o2, o1, o0};
    endfunction

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(99);
        if (calm || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic wait_idle();
        while (corrected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_COLOR_MODE: mode_color   = val[0];
            CFG_CENTER_X:   cen_x        = val[12:0];
            CFG_CENTER_Y:   cen_y        = val[12:0];
            CFG_COEF_CH0:   gain_coef[0] = val[62:0];
            CFG_COEF_CH1:   gain_coef[1] = val[62:0];
            CFG_COEF_CH2:   gain_coef[2] = val[62:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_pixel(pixel_t p, bit typed, logic [23:0] outs);
        s_tdata  <= {6'd0, p.ch2, p.ch1, p.ch0, p.row, p.col};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        corrected_q.push_back(typed ? outs : corrected_pixel(p));
        begin
            int gap;
            gap = idle_len();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic pixel_t random_pixel();
        pixel_t p;
        int     roll;
        p.ch0 = 8'($urandom_range(255));
        p.ch1 = 8'($urandom_range(255));
        p.ch2 = 8'($urandom_range(255));
        roll = $urandom_range(99);
        // most pixels sit within a few radius units of the centre
        if (roll < 75)
        begin
            p.col = cen_x + 13'($urandom_range(3000)) - 13'd1500;
            p.row = cen_y + 13'($urandom_range(3000)) - 13'd1500;
        end
        else
        begin
            p.col = 13'($urandom_range(8191));
            p.row = 13'($urandom_range(8191));
        end
        return p;
    endfunction

    function automatic logic [62:0] random_coef();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 63'({$urandom, $urandom});
        return pack_coef($urandom_range(262144) - 131072,
                         $urandom_range(16384) - 8192,
                         $urandom_range(2048) - 1024);
    endfunction

    pixel_row_t directed [] = '{
        // reset state: mono, gain one, other channels zero
        '{'{13'd0, 13'd0, 8'd0, 8'd255, 8'd255}, 1'b1, 24'h000000},
        '{'{13'd8191, 13'd8191, 8'd255, 8'd77, 8'd1}, 1'b1, 24'h0000FF},
        '{'{13'd100, 13'd200, 8'd93, 8'd0, 8'd0}, 1'b1, 24'h00005D},
        // color; ch0 hits zero divisor at unit radius, ch1 goes negative,
        // ch2 has unit gain
        '{'{13'd0, 13'd0, 8'd255, 8'd128, 8'd7}, 1'b1, 24'h0780FF},
        '{'{13'd1024, 13'd0, 8'd200, 8'd200, 8'd200}, 1'b1, 24'hC800FF},
        '{'{13'd1024, 13'd0, 8'd0, 8'd255, 8'd0}, 1'b1, 24'h000000},
        '{'{13'd0, 13'd1024, 8'd1, 8'd1, 8'd255}, 1'b1, 24'hFF00FF},
        '{'{13'd8191, 13'd8191, 8'd255, 8'd255, 8'd255}, 1'b0, 24'h0},
        '{'{13'd8191, 13'd0, 8'd10, 8'd20, 8'd30}, 1'b0, 24'h0},
        '{'{13'd700, 13'd300, 8'd50, 8'd60, 8'd70}, 1'b0, 24'h0},
        '{'{13'd1000, 13'd0, 8'd255, 8'd255, 8'd255}, 1'b0, 24'h0},
        '{'{13'd1023, 13'd0, 8'd255, 8'd3, 8'd3}, 1'b0, 24'h0},
        '{'{13'd4096, 13'd2048, 8'd170, 8'd85, 8'd170}, 1'b0, 24'h0}
    };

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        mode_color = 1'b0;
        cen_x      = '0;
        cen_y      = '0;
        gain_coef  = '{default: '0};
        mismatches = 0;
        calm       = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (i == RESET_ROWS)
            begin
                s_tvalid <= 1'b0;
                wait_idle();
                write_reg(CFG_COLOR_MODE, 64'd1);
                write_reg(CFG_CENTER_X, 64'd0);
                write_reg(CFG_CENTER_Y, 64'd0);
                write_reg(CFG_COEF_CH0, 64'(pack_coef(-131072, 0, 0)));
                write_reg(CFG_COEF_CH1, 64'(pack_coef(-1048576, 0, 0)));
                write_reg(CFG_COEF_CH2, 64'd0);
                // unused indexes must leave everything alone
                write_reg(CFG_SPARE_6, '1);
                write_reg(CFG_SPARE_7, '1);
            end
            send_pixel(directed[i].pix, directed[i].typed, directed[i].outs);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            s_tvalid <= 1'b0;
            wait_idle();
            calm = (ph == 2);
            write_reg(CFG_COLOR_MODE, (ph == 1 || ph == 5) ? 64'd0 : 64'd1);
            if (ph == 3)
            begin
                write_reg(CFG_CENTER_X, 64'd8191);
                write_reg(CFG_CENTER_Y, 64'd8191);
                write_reg(CFG_COEF_CH0, {1'b0, {63{1'b1}}});
                write_reg(CFG_COEF_CH1, 64'(pack_coef(1048575, 1048575, 1048575)));
                write_reg(CFG_COEF_CH2, 64'(pack_coef(-1048576, -1048576, -1048576)));
            end
            else
            begin
                write_reg(CFG_CENTER_X, 64'($urandom_range(8191)));
                write_reg(CFG_CENTER_Y, 64'($urandom_range(8191)));
                write_reg(CFG_COEF_CH0, 64'(random_coef()));
                write_reg(CFG_COEF_CH1, 64'(random_coef()));
                write_reg(CFG_COEF_CH2, 64'(random_coef()));
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_pixel(random_pixel(), 1'b0, 24'h0);
                // hold off once mid-stream until the pipe has drained
                if (ph == 4 && n == PHASE_ITEMS / 2)
                begin
                    s_tvalid <= 1'b0;
                    while (corrected_q.size() != 0)
                        @(posedge clk);
                end
            end
        end
        s_tvalid <= 1'b0;

        while (corrected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
        if (mismatches == 0 && corrected_q.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // output side: random stalls and the comparison
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= (idle_len() == 0);
            if (m_tvalid && m_tready)
            begin
                if (corrected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item %h", m_tdata);
                end
                else
                begin
                    logic [23:0] want;
                    want = corrected_q.pop_front();
                    if (want !== m_tdata)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: ch0 %0d/%0d ch1 %0d/%0d ch2 %0d/%0d (exp/act)",
                                     want[7:0], m_tdata[7:0], want[15:8], m_tdata[15:8],
                                     want[23:16], m_tdata[23:16]);
                    end
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

endmodule
